/* hdl/iphs_pkg.sv */
// ----------------------------------------------------------------------------
// iphs_pkg
// Shared types and constants of the IPv4 address hash set.
// ----------------------------------------------------------------------------
package iphs_pkg;

    localparam int ADDR_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK
    } t_state;

    // one slot of a bucket
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } t_slot;

endpackage

/* hdl/iphs_mod_unit.sv */
// ----------------------------------------------------------------------------
// iphs_mod_unit
// Remainder of a 32-bit word by a constant divisor in three registered
// steps: fold the upper half, reciprocal multiply, subtract.
// ----------------------------------------------------------------------------
module iphs_mod_unit
    import iphs_pkg::*;
#(
    parameter int DIVISOR = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    output logic              o_done,
    output logic [(DIVISOR > 1 ? $clog2(DIVISOR) : 1)-1:0] o_remainder
);

    localparam int OUT_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
    localparam int LOG_D   = $clog2(DIVISOR);
    localparam int HALF_W  = ADDR_W / 2;
    // hi * (2^HALF_W mod DIVISOR) + lo stays below 2^FOLD_W
    localparam int FOLD_W  = HALF_W + OUT_W + 1;
    localparam int SHIFT   = FOLD_W + LOG_D;
    localparam int RECIP_W = FOLD_W + 1;
    localparam int PROD_W  = FOLD_W + RECIP_W;
    localparam logic [63:0] HI_WEIGHT = (64'd1 << HALF_W) % 64'(DIVISOR);
    // rounded-up reciprocal, exact for every folded value
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic              r_fold_vld;
    logic              r_quot_vld;
    logic              r_done;
    logic [FOLD_W-1:0] r_fold, n_fold;
    logic [FOLD_W-1:0] r_quot, n_quot;
    logic [OUT_W-1:0]  r_rem, n_rem;
    logic [PROD_W-1:0] prod;
    logic [FOLD_W-1:0] rem_full;

    always_comb begin
        n_fold   = FOLD_W'(i_dividend[ADDR_W-1:HALF_W]) * FOLD_W'(HI_WEIGHT)
                 + FOLD_W'(i_dividend[HALF_W-1:0]);
        prod     = PROD_W'(r_fold) * PROD_W'(RECIP);
        n_quot   = FOLD_W'(prod >> SHIFT);
        rem_full = r_fold - (r_quot * FOLD_W'(DIVISOR));
        n_rem    = OUT_W'(rem_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_vld <= 1'b0;
            r_quot_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_fold_vld <= i_start;
            r_quot_vld <= r_fold_vld;
            r_done     <= r_quot_vld;
        end
        if (i_start) begin
            r_fold <= n_fold;
        end
        if (r_fold_vld) begin
            r_quot <= n_quot;
        end
        if (r_quot_vld) begin
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

/* hdl/iphs_slot_ram.sv */
// ----------------------------------------------------------------------------
// iphs_slot_ram
// Slot store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iphs_slot_ram
    import iphs_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ip_address_hash_set.sv */
// ----------------------------------------------------------------------------
// ip_address_hash_set
// Set of IPv4 addresses in NUM_BUCKETS buckets of BUCKET_WAYS slots each.
// ----------------------------------------------------------------------------
// Usage: pulse start with i_operation/i_ip_addr while busy is low. Each
// command returns exactly one result beat, o_done high for one cycle with
// o_hit and o_full_res; the receiver cannot stall it, so sample it then.
// After reset the block runs a clearing pass (busy high) that invalidates
// every slot. A command then forms the bucket (address mod NUM_BUCKETS)
// by folding the upper half, a reciprocal multiply and a subtract, each
// step registered. It then reads and checks the bucket's slots in turn,
// each in a read state and a check state, since the slot store has a
// single read port with registered data. Busy drops in the cycle o_done
// shows, so the next command may start there.
// Insert takes the lowest free slot (no duplicate check) or reports full;
// delete frees the lowest matching slot and reports hit; lookup reports
// hit on any match. Operation code 3 changes nothing and returns zeros.
// ----------------------------------------------------------------------------
module ip_address_hash_set
    import iphs_pkg::*;
#(
    parameter int NUM_BUCKETS = 64,
    parameter int BUCKET_WAYS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_operation,
    input  logic [ADDR_W-1:0] i_ip_addr,
    output logic              o_done,
    output logic              o_hit,
    output logic              o_full_res
);

    localparam int SLOTS  = NUM_BUCKETS * BUCKET_WAYS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W  = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [WAY_W-1:0]  r_way, n_way;
    t_op               r_op, n_op;
    logic [ADDR_W-1:0] r_ip, n_ip;
    logic              r_done, n_done;
    logic              r_hit, n_hit;
    logic              r_full, n_full;

    logic              accept;
    logic              mod_done;
    logic [BKT_W-1:0]  bucket;
    logic              ram_we;
    t_slot             ram_wdata;
    t_slot             ram_rdata;
    logic              match;
    logic              last_way;

    assign accept   = start && (r_state == ST_IDLE);
    assign match    = ram_rdata.valid && (ram_rdata.addr == r_ip);
    assign last_way = (r_way == WAY_W'(BUCKET_WAYS - 1));

    iphs_mod_unit #(
        .DIVISOR (NUM_BUCKETS)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_dividend  (i_ip_addr),
        .o_done      (mod_done),
        .o_remainder (bucket)
    );

    iphs_slot_ram #(
        .DEPTH (SLOTS),
        .IDX_W (SLOT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_slot  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_done  <= n_done;
        end
        r_way  <= n_way;
        r_op   <= n_op;
        r_ip   <= n_ip;
        r_hit  <= n_hit;
        r_full <= n_full;
    end

    always_comb begin
        n_state         = r_state;
        n_slot          = r_slot;
        n_way           = r_way;
        n_op            = r_op;
        n_ip            = r_ip;
        n_done          = 1'b0;
        n_hit           = r_hit;
        n_full          = r_full;
        ram_we          = 1'b0;
        ram_wdata.valid = 1'b0;
        ram_wdata.addr  = r_ip;

        case (r_state)
            ST_CLEAR: begin
                // invalidate one slot per cycle
                ram_we = 1'b1;
                n_slot = r_slot + SLOT_W'(1);
                if (r_slot == SLOT_W'(SLOTS - 1)) begin
                    n_slot  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_ip    = i_ip_addr;
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                if (mod_done) begin
                    n_slot  = SLOT_W'(32'(bucket) * BUCKET_WAYS);
                    n_way   = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // slot address presented; data arrives next cycle
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_hit  = 1'b0;
                n_full = 1'b0;
                if (r_op == OP_INSERT && !ram_rdata.valid) begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b1;
                    n_done          = 1'b1;
                    n_state         = ST_IDLE;
                end else if (r_op == OP_DELETE && match) begin
                    ram_we  = 1'b1;
                    n_hit   = 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_op == OP_LOOKUP && match) begin
                    n_hit   = 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (last_way) begin
                    n_full  = (r_op == OP_INSERT);
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_slot  = r_slot + SLOT_W'(1);
                    n_way   = r_way + WAY_W'(1);
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_hit      = r_hit;
    assign o_full_res = r_full;

`ifndef SYNTHESIS
    // a command starts the bucket hash at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && r_state == ST_HASH))
        else $error("accepted command did not enter hashing");

    // the result beat comes only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // hit and full are mutually exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_full_res))
        else $error("hit and full both set");

    // one result beat per command
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result beats");

    // store writes only during clearing or the slot check
    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_CLEAR || r_state == ST_CHECK))
        else $error("slot write outside clear or check");
`endif

endmodule
